// ----- rtl/core/bpd_pkg.sv -----
// bpd_pkg: packet geometry, marker bytes, window and sample types and
// the channel unpacking function for the biosignal packet deframer
// no dependencies
package bpd_pkg;

  localparam int PACKET_BYTES = 33;                    // legal range 27..64
  localparam int HIST_BYTES   = PACKET_BYTES - 1;      // bytes held before the newest
  localparam int FILL_W       = $clog2(PACKET_BYTES);  // holds 0..HIST_BYTES
  localparam int CHANNELS     = 8;
  localparam int FIRST_BYTE   = 2;
  localparam int SAMPLE_W     = 24;

  localparam logic [7:0] START_MARK = 8'hA0;
  localparam logic [7:0] STOP_MARK  = 8'hC0;
  localparam logic [7:0] STOP_MASK  = 8'hF0;

  typedef logic [7:0]                       byte_t;
  typedef logic signed [SAMPLE_W-1:0]       sample_t;
  typedef logic [FILL_W-1:0]                fill_t;
  // element 0 is the newest held byte, element HIST_BYTES-1 the oldest
  typedef logic [HIST_BYTES-1:0][7:0]       win_t;

  typedef struct packed {
    logic near_full;  // next accepted byte completes a full window
    logic hit;        // oldest and incoming bytes frame a packet
    logic enabled;    // streaming enable register
  } bpd_win_stat_t;

  // channel k is packet bytes FIRST_BYTE+3k .. FIRST_BYTE+3k+2, big-endian;
  // packet byte i sits at window element HIST_BYTES-1-i
  function automatic sample_t get_sample(input win_t w, input int k);
    int pos;
    pos = FIRST_BYTE + 3 * k;
    return sample_t'({w[HIST_BYTES-1-pos], w[HIST_BYTES-2-pos], w[HIST_BYTES-3-pos]});
  endfunction

endpackage

// ----- rtl/core/biosignal_packet_deframer_core.sv -----
// biosignal_packet_deframer_core: top level of the packet deframer, result
// register and channel unpacking; uses bpd_pkg and bpd_window
//
//  channel   ports                        direction  word
//  input     in_valid in_stall in_rx_byte  in         one serial byte
//  result    out_valid out_stall out_channel_0..7     out  eight 24-bit samples
//  config    cfg_we cfg_wdata              in         streaming enable
//
// one byte per cycle while in_stall is low; a packet's samples appear in the result
// register in the cycle after the byte that closes it is taken
// reset clears the fill count, the streaming enable and the result valid;
// no clearing pass is needed
// in_stall rises only while a result waits and the next byte could close a
// packet; all other bytes are taken even when the result side stalls
module biosignal_packet_deframer_core import bpd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  byte_t   in_rx_byte,
  output logic    out_valid,
  input  logic    out_stall,
  output sample_t out_channel_0,
  output sample_t out_channel_1,
  output sample_t out_channel_2,
  output sample_t out_channel_3,
  output sample_t out_channel_4,
  output sample_t out_channel_5,
  output sample_t out_channel_6,
  output sample_t out_channel_7,
  input  logic    cfg_we,
  input  logic    cfg_wdata
);

  win_t          win;
  bpd_win_stat_t stat;
  logic          take;
  logic          emit;

  // result register
  logic                         out_valid_r, out_valid_nxt;
  sample_t [CHANNELS-1:0]       chan_r, chan_nxt;

  // stall only when a waiting result could be overrun by a new packet
  assign in_stall = out_valid_r && out_stall && stat.near_full;
  assign take     = in_valid && !in_stall;
  assign emit     = take && stat.hit;

  bpd_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .byte_take (take),
    .byte_in   (in_rx_byte),
    .win       (win),
    .stat      (stat)
  );

  // unpack the eight big-endian samples straight from the held bytes
  always_comb begin
    chan_nxt = chan_r;
    if (emit) begin
      for (int k = 0; k < CHANNELS; k++) begin
        chan_nxt[k] = get_sample(win, k);
      end
    end
  end

  always_comb begin
    priority if (emit) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chan_r <= chan_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_channel_0 = chan_r[0];
  assign out_channel_1 = chan_r[1];
  assign out_channel_2 = chan_r[2];
  assign out_channel_3 = chan_r[3];
  assign out_channel_4 = chan_r[4];
  assign out_channel_5 = chan_r[5];
  assign out_channel_6 = chan_r[6];
  assign out_channel_7 = chan_r[7];

  // a new result only follows a byte that closed a packet
  a_rise_from_hit : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(emit))
    else $error("result appeared without a closing byte");

  // a waiting result is never overwritten
  a_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !emit)
    else $error("packet closed while result stalled");

  // stall is raised only with a waiting result
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with no result waiting");

endmodule

// ----- rtl/core/bpd_window.sv -----
// bpd_window: byte shift line, fill count, streaming enable and packet
// boundary check for the deframer; uses bpd_pkg
module bpd_window import bpd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  input  logic          byte_take,   // a word is accepted this cycle
  input  byte_t         byte_in,
  output win_t          win,
  output bpd_win_stat_t stat
);

  win_t  win_r, win_nxt;
  fill_t fill_r, fill_nxt;
  logic  en_r, en_nxt;
  logic  store;

  assign store = byte_take && en_r;

  always_comb begin
    stat.enabled   = en_r;
    stat.near_full = (fill_r == FILL_W'(HIST_BYTES));
    stat.hit       = en_r && stat.near_full && (win_r[HIST_BYTES-1] == START_MARK)
                     && ((byte_in & STOP_MASK) == STOP_MARK);
  end

  always_comb begin
    win_nxt  = win_r;
    fill_nxt = fill_r;
    en_nxt   = en_r;
    priority if (cfg_we) begin
      en_nxt   = cfg_wdata;
      fill_nxt = '0;
    end else if (store) begin
      win_nxt = {win_r[HIST_BYTES-2:0], byte_in};
      priority if (stat.hit) fill_nxt = '0;
      else if (stat.near_full) fill_nxt = fill_r;  // oldest byte slides out
      else fill_nxt = fill_r + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      en_r   <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      en_r   <= en_nxt;
    end
  end

  // payload shift line, no reset needed: fill count gates its use
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  assign win = win_r;

  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(HIST_BYTES))
    else $error("fill count beyond window");

  a_hit_empties : assert property (@(posedge clk) disable iff (!rst_n)
    (store && stat.hit && !cfg_we) |=> (fill_r == '0))
    else $error("window not emptied after packet");

  a_disabled_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (!en_r && !cfg_we) |=> $stable(fill_r))
    else $error("fill count moved while streaming disabled");

endmodule

// ----- verif/bpd_frame_checker.sv -----
// bpd_frame_checker: watches the byte, result and enable ports of the packet deframer,
// predicts decoded frames from a window model of its own and compares them channel by channel
// depends on bpd_pkg
module bpd_frame_checker import bpd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_stall,
  input  byte_t   in_rx_byte,
  input  logic    out_valid,
  input  logic    out_stall,
  input  sample_t out_channel_0,
  input  sample_t out_channel_1,
  input  sample_t out_channel_2,
  input  sample_t out_channel_3,
  input  sample_t out_channel_4,
  input  sample_t out_channel_5,
  input  sample_t out_channel_6,
  input  sample_t out_channel_7,
  input  logic    cfg_we,
  input  logic    cfg_wdata,
  output int      fail_count,
  output int      pending,
  output int      frames_done
);
  timeunit 1ns;
  timeprecision 1ps;

  // channel k in slice k
  typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] frame_t;

  byte_t  rx_window [PACKET_BYTES];
  int     rx_fill;
  logic   streaming_on;
  frame_t pending_frames [$];
  frame_t got_frame;
  frame_t want_frame;

  assign got_frame = {out_channel_7, out_channel_6, out_channel_5, out_channel_4,
                      out_channel_3, out_channel_2, out_channel_1, out_channel_0};

  task automatic flag(input string msg);
    $display("mismatch: %s", msg);
    fail_count++;
  endtask

  // one accepted byte through the window model
  task automatic shift_in_byte(input byte_t b);
    frame_t f;
    if (!streaming_on) return;
    if (rx_fill >= PACKET_BYTES) rx_fill = PACKET_BYTES - 1;
    rx_window[rx_fill] = b;
    rx_fill++;
    if (rx_fill < PACKET_BYTES) return;
    if (rx_window[0] == START_MARK &&
        (rx_window[PACKET_BYTES-1] & STOP_MASK) == STOP_MARK) begin
      for (int k = 0; k < CHANNELS; k++)
        f[k] = {rx_window[FIRST_BYTE+3*k], rx_window[FIRST_BYTE+3*k+1],
                rx_window[FIRST_BYTE+3*k+2]};
      pending_frames = {pending_frames, f};
      rx_fill = 0;
    end else begin
      for (int i = 0; i < PACKET_BYTES - 1; i++) rx_window[i] = rx_window[i+1];
      rx_fill = PACKET_BYTES - 1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      streaming_on = 1'b0;
      rx_fill = 0;
      for (int i = 0; i < PACKET_BYTES; i++) rx_window[i] = '0;
      pending_frames.delete();
    end else begin
      // results first: a frame cannot leave in the cycle its closing byte arrives
      if (out_valid && !out_stall) begin
        if (pending_frames.size() == 0) begin
          flag($sformatf("result word %0d with no frame waiting", frames_done));
        end else begin
          want_frame = pending_frames.pop_front();
          for (int k = 0; k < CHANNELS; k++)
            if (got_frame[k] !== want_frame[k])
              flag($sformatf("frame %0d channel %0d: got %0d, want %0d", frames_done, k,
                             $signed(got_frame[k]), $signed(want_frame[k])));
        end
        frames_done++;
      end
      if (cfg_we) begin
        streaming_on = cfg_wdata;
        rx_fill = 0;
      end
      if (in_valid && !in_stall) shift_in_byte(in_rx_byte);
    end
    pending = pending_frames.size();
  end

endmodule

// ----- verif/tb_biosignal_packet_deframer_core.sv -----
// tb_biosignal_packet_deframer_core: byte stimulus, enable writes and verdict for the deframer
// depends on bpd_pkg, biosignal_packet_deframer_core and bpd_frame_checker
module tb_biosignal_packet_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import bpd_pkg::*;

  localparam int ITEMS       = 1350;  // least number of streamed bytes in the whole run
  localparam int QUIET_TAIL  = 150;   // last bytes sent with no idling on either side
  localparam int MAX_GAP     = 17;
  localparam int SETTLE      = 4;     // result register follows the closing byte in the next cycle
  // longest legal silence is a sender gap plus a result stall plus the SETTLE wait of an enable write
  localparam int STUCK_LIMIT = 2000;

  // channel values of the directed frame: both extremes, zero, minus one, alternating bits
  localparam logic [CHANNELS-1:0][SAMPLE_W-1:0] CORNER_SAMPLES = {
    24'hAAAAAA, 24'h555555, 24'h7FFFFF, 24'h800000,
    24'hFFFFFF, 24'h000000, 24'h7FFFFF, 24'h800000};

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  byte_t   in_rx_byte = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  sample_t out_channel_0, out_channel_1, out_channel_2, out_channel_3;
  sample_t out_channel_4, out_channel_5, out_channel_6, out_channel_7;
  logic    cfg_we = 1'b0;
  logic    cfg_wdata = 1'b0;

  int fail_count;
  int pending;
  int frames_done;

  // stimulus bookkeeping
  bit stream_on = 1'b0;  // mirror of the enable register
  bit calm = 1'b0;       // sender stretch without gaps
  bit no_idle = 1'b0;    // tail of the run: nobody idles
  int fed_bytes = 0;     // bytes sent while streaming
  int dropped_bytes = 0; // bytes sent while streaming was off
  int cfg_writes = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  biosignal_packet_deframer_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_channel_0 (out_channel_0),
    .out_channel_1 (out_channel_1),
    .out_channel_2 (out_channel_2),
    .out_channel_3 (out_channel_3),
    .out_channel_4 (out_channel_4),
    .out_channel_5 (out_channel_5),
    .out_channel_6 (out_channel_6),
    .out_channel_7 (out_channel_7),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  bpd_frame_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_channel_0 (out_channel_0),
    .out_channel_1 (out_channel_1),
    .out_channel_2 (out_channel_2),
    .out_channel_3 (out_channel_3),
    .out_channel_4 (out_channel_4),
    .out_channel_5 (out_channel_5),
    .out_channel_6 (out_channel_6),
    .out_channel_7 (out_channel_7),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .frames_done   (frames_done)
  );

  // one byte word; entered and left at a falling edge, held until taken
  task automatic send_byte(input byte_t b);
    int gap;
    if (!calm && !no_idle && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, MAX_GAP);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_rx_byte = b;
    // in_stall read here is the value before the edge, the one that decides
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (stream_on) fed_bytes++;
    else dropped_bytes++;
  endtask

  // enable write only once every frame is out and the result register has settled
  task automatic set_streaming(input bit on);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = on;
    @(negedge clk);
    cfg_we = 1'b0;
    stream_on = on;
    cfg_writes++;
  endtask

  // noise leans on the marker bytes so false starts and false stops show up
  function automatic byte_t noise_byte();
    case ($urandom_range(0, 3))
      0: return START_MARK;
      1: return STOP_MARK | byte_t'($urandom_range(0, 15));
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  // a 33-byte frame, optionally with a broken start or stop marker, sent up to len bytes
  task automatic send_frame(input bit start_ok, input bit stop_ok, input int len,
                            input bit corners);
    byte_t pkt [PACKET_BYTES];
    logic [SAMPLE_W-1:0] s;
    for (int i = 0; i < PACKET_BYTES; i++) pkt[i] = byte_t'($urandom_range(0, 255));
    if (start_ok) pkt[0] = START_MARK;
    else if (pkt[0] == START_MARK) pkt[0] ^= 8'h01;
    for (int k = 0; k < CHANNELS; k++) begin
      if (corners) begin
        s = CORNER_SAMPLES[k];
      end else begin
        case ($urandom_range(0, 7))
          0: s = 24'h800000;
          1: s = 24'h7FFFFF;
          2: s = 24'h000000;
          3: s = 24'hFFFFFF;
          default: s = SAMPLE_W'($urandom);
        endcase
      end
      pkt[FIRST_BYTE+3*k]   = s[23:16];
      pkt[FIRST_BYTE+3*k+1] = s[15:8];
      pkt[FIRST_BYTE+3*k+2] = s[7:0];
    end
    if (corners) pkt[PACKET_BYTES-1] = STOP_MARK | 8'h0F;
    else if (stop_ok) pkt[PACKET_BYTES-1] = STOP_MARK | byte_t'($urandom_range(0, 15));
    else if ((pkt[PACKET_BYTES-1] & STOP_MASK) == STOP_MARK) pkt[PACKET_BYTES-1] ^= 8'h80;
    for (int i = 0; i < len; i++) send_byte(pkt[i]);
  endtask

  // result side: free stretches, sometimes long, broken by stall bursts
  initial begin
    int run;
    forever begin
      out_stall = 1'b0;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, MAX_GAP);
      repeat (run) @(negedge clk);
      if (!no_idle && $urandom_range(0, 3) != 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, MAX_GAP)) @(negedge clk);
      end
    end
  end

  // watchdog: ends the run when no word moves on either channel for too long
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("watchdog: no word moved for %0d cycles", STUCK_LIMIT);
    $display("tb_biosignal_packet_deframer_core failed");
    $finish;
  end

  initial begin
    int kind;
    int n;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // streaming is off after reset: these bytes must vanish
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(START_MARK);
    send_byte(STOP_MARK);
    set_streaming(1'b1);
    // one frame carrying the extreme channel values
    send_frame(1'b1, 1'b1, PACKET_BYTES, 1'b1);

    // random part: mostly clean frames, some noise, broken frames and enable phases
    while (fed_bytes < ITEMS) begin
      no_idle = (fed_bytes >= ITEMS - QUIET_TAIL);
      kind = $urandom_range(0, 19);
      if (kind < 15) begin
        send_frame(1'b1, 1'b1, PACKET_BYTES, 1'b0);
      end else if (kind == 15) begin
        n = $urandom_range(1, 12);
        repeat (n) send_byte(noise_byte());
      end else if (kind == 16) begin
        // one of the two markers wrong: the window slides instead of decoding
        n = $urandom_range(0, 1);
        send_frame(n[0], !n[0], PACKET_BYTES, 1'b0);
      end else if (kind == 17) begin
        // cut-off frame, often followed by a rewrite that empties the window
        send_frame(1'b1, 1'b1, $urandom_range(1, PACKET_BYTES - 1), 1'b0);
        if ($urandom_range(0, 1)) set_streaming(1'b1);
      end else if (kind == 18) begin
        set_streaming(1'b0);
        if ($urandom_range(0, 1)) set_streaming(1'b0);
        n = $urandom_range(2, 8);
        repeat (n) send_byte(noise_byte());
        set_streaming(1'b1);
      end else begin
        calm = !calm;
      end
    end

    // drain: every frame out, then a settling wait for anything stray
    in_valid = 1'b0;
    no_idle = 1'b1;
    while (pending != 0) @(negedge clk);
    repeat (2 * SETTLE) @(negedge clk);

    $display("covered %0d streamed bytes, %0d bytes sent while disabled, %0d enable writes",
             fed_bytes, dropped_bytes, cfg_writes);
    $display("%0d decoded frames compared, %0d mismatches", frames_done, fail_count);
    if (fail_count == 0) begin
      $display("tb_biosignal_packet_deframer_core passed");
    end else begin
      $display("tb_biosignal_packet_deframer_core failed");
    end
    $finish;
  end

endmodule
